FILE: rtl/core/tdt_pkg.sv
package tdt_pkg;

    // Table geometry.
    localparam int KEY_SLOTS    = 256;
    localparam int DEPS_PER_KEY = 16;
    localparam int ID_BITS      = 32;

    // Derived widths.
    localparam int KEY_BITS = 32 + 64 + 64 + 4 * 64;
    localparam int SLOT_W   = $clog2(KEY_SLOTS);
    localparam int SLOT_CW  = $clog2(KEY_SLOTS + 1);
    localparam int ENT_W    = (DEPS_PER_KEY > 1) ? $clog2(DEPS_PER_KEY) : 1;
    localparam int ENT_CW   = $clog2(DEPS_PER_KEY + 1);
    localparam int DEP_AW   = (KEY_SLOTS * DEPS_PER_KEY > 1) ?
                              $clog2(KEY_SLOTS * DEPS_PER_KEY) : 1;

    // Access modes.
    typedef enum logic [1:0] {
        MODE_RECORD  = 2'd0,
        MODE_ANALYZE = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    // One classified access as it travels from the front to the back.
    typedef struct packed {
        mode_t               mode;
        logic [ID_BITS-1:0]  id;
        logic                wr;
        logic                last;
        logic [KEY_BITS-1:0] key;
    } item_t;

endpackage

FILE: rtl/core/transaction_dependency_table_unit.sv
// Steps from an accepted item to its result register: a pop, a key scan over the key
// store's read port at one slot per cycle (a hit ends it early), an allocate step (new
// record key) or a mask step (key hit), a list walk (analyze, release) and a hand-over.
// The back handles one access at a time, from its pop to its hand-over; the hand-over
// waits while out_stall holds the previous result.
// Reset: asynchronous, active low; clears the queue, slot-used bits and best candidate.
module transaction_dependency_table_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] txn_id,
    input  logic        is_write,
    input  logic [31:0] addr_upper,
    input  logic [63:0] addr_lower,
    input  logic [63:0] addr_middle,
    input  logic [63:0] slot_word3,
    input  logic [63:0] slot_word2,
    input  logic [63:0] slot_word1,
    input  logic [63:0] slot_word0,
    input  logic        last_access,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        wait_found,
    output logic [31:0] wait_id,
    output logic        overflow
);
    import tdt_pkg::*;

    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    // Front: accept and classify.
    tdt_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .txn_id      (txn_id),
        .is_write    (is_write),
        .addr_upper  (addr_upper),
        .addr_lower  (addr_lower),
        .addr_middle (addr_middle),
        .slot_word3  (slot_word3),
        .slot_word2  (slot_word2),
        .slot_word1  (slot_word1),
        .slot_word0  (slot_word0),
        .last_access (last_access),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // Back: table lookup, update and result.
    tdt_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .wait_found (wait_found),
        .wait_id    (wait_id),
        .overflow   (overflow)
    );

    // An overflow result never reports a wait target.
    a_ovf_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> !wait_found)
        else $error("overflow result carries a wait target");

    // Without a wait target the id is zero.
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !wait_found |-> wait_id == 32'd0)
        else $error("wait id set without wait target");

    // The queue only drains through a pop by the back.
    a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(q_valid) |-> $past(q_pop))
        else $error("queue emptied without a pop");

endmodule

FILE: rtl/core/tdt_front.sv
module tdt_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  logic [31:0]       txn_id,
    input  logic              is_write,
    input  logic [31:0]       addr_upper,
    input  logic [63:0]       addr_lower,
    input  logic [63:0]       addr_middle,
    input  logic [63:0]       slot_word3,
    input  logic [63:0]       slot_word2,
    input  logic [63:0]       slot_word1,
    input  logic [63:0]       slot_word0,
    input  logic              last_access,
    output logic              q_valid,
    output tdt_pkg::item_t    q_item,
    input  logic              q_pop
);
    import tdt_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    item_t      in_item;
    logic       push;
    logic       pop;

    // Classify the incoming item; the unused mode, MODE_NONE, is dropped at the push.
    always_comb
    begin
        in_item.mode = mode_t'(mode);
        in_item.id   = ID_BITS'(64'(txn_id));
        in_item.wr   = is_write;
        in_item.last = last_access;
        in_item.key  = {addr_upper, addr_middle, addr_lower,
                        slot_word3, slot_word2, slot_word1, slot_word0};
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall && (mode_t'(mode) != MODE_NONE);
    assign pop      = q_pop && (cnt_reg != 2'd0);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    // Pointer and fill count of the two-entry queue.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/core/tdt_back.sv
module tdt_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  tdt_pkg::item_t    q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              wait_found,
    output logic [31:0]       wait_id,
    output logic              overflow
);
    import tdt_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_ALLOC = 7'b0000100,
        ST_MASK  = 7'b0001000,
        ST_WALK  = 7'b0010000,
        ST_FIN   = 7'b0100000,
        ST_WAIT  = 7'b1000000
    } state_t;

    // Memories: key words, per-key entry masks, and entry contents.
    logic [KEY_BITS-1:0]     key_mem  [KEY_SLOTS];
    logic [DEPS_PER_KEY-1:0] mask_mem [KEY_SLOTS];
    logic [ID_BITS:0]        dep_mem  [KEY_SLOTS * DEPS_PER_KEY];

    logic [KEY_BITS-1:0]     key_q;
    logic [DEPS_PER_KEY-1:0] mask_q;
    logic [ID_BITS:0]        dep_q;

    logic                    key_we;
    logic [SLOT_W-1:0]       key_waddr;
    logic [SLOT_W-1:0]       key_raddr;
    logic                    mask_we;
    logic [SLOT_W-1:0]       mask_waddr;
    logic [DEPS_PER_KEY-1:0] mask_wdata;
    logic [SLOT_W-1:0]       mask_raddr;
    logic                    dep_we;
    logic [DEP_AW-1:0]       dep_waddr;
    logic [DEP_AW-1:0]       dep_raddr;

    state_t                  state_reg, state_next;
    item_t                   item_reg, item_next;
    logic [SLOT_CW-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                    rs_vld_reg, rs_vld_next;
    logic [SLOT_W-1:0]       rs_idx_reg, rs_idx_next;
    logic                    free_found_reg, free_found_next;
    logic [SLOT_W-1:0]       free_slot_reg, free_slot_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [DEPS_PER_KEY-1:0] mask_reg, mask_next;
    logic [ENT_CW-1:0]       iss_cnt_reg, iss_cnt_next;
    logic                    rdv_reg, rdv_next;
    logic [ENT_W-1:0]        rd_e_reg, rd_e_next;
    logic                    best_found_reg, best_found_next;
    logic [ID_BITS-1:0]      best_txn_reg, best_txn_next;
    logic                    res_need_reg, res_need_next;
    logic                    res_ovf_reg, res_ovf_next;
    logic [KEY_SLOTS-1:0]    key_used_reg, key_used_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_found_reg, out_found_next;
    logic [31:0]             out_id_reg, out_id_next;
    logic                    out_ovf_reg, out_ovf_next;

    logic                    hit;
    logic                    zero_found;
    logic [ENT_W-1:0]        zero_idx;
    logic [ID_BITS-1:0]      ent_txn;
    logic                    ent_wr;

    // Lowest clear bit of the entry mask.
    always_comb
    begin
        zero_found = 1'b0;
        zero_idx   = '0;
        for (int i = DEPS_PER_KEY - 1; i >= 0; i--)
        begin
            if (!mask_q[i])
            begin
                zero_found = 1'b1;
                zero_idx   = ENT_W'(i);
            end
        end
    end

    assign hit     = rs_vld_reg && key_used_reg[rs_idx_reg] && (key_q == item_reg.key);
    assign ent_txn = dep_q[ID_BITS-1:0];
    assign ent_wr  = dep_q[ID_BITS];

    assign key_raddr  = scan_cnt_reg[SLOT_W-1:0];
    assign mask_raddr = rs_idx_reg;
    assign dep_raddr  = DEP_AW'(32'(slot_reg) * DEPS_PER_KEY + 32'(iss_cnt_reg));

    // Sequencer for one access.
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        scan_cnt_next   = scan_cnt_reg;
        rs_vld_next     = 1'b0;
        rs_idx_next     = rs_idx_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        slot_next       = slot_reg;
        mask_next       = mask_reg;
        iss_cnt_next    = iss_cnt_reg;
        rdv_next        = 1'b0;
        rd_e_next       = rd_e_reg;
        best_found_next = best_found_reg;
        best_txn_next   = best_txn_reg;
        res_need_next   = res_need_reg;
        res_ovf_next    = res_ovf_reg;
        key_used_next   = key_used_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_found_next  = out_found_reg;
        out_id_next     = out_id_reg;
        out_ovf_next    = out_ovf_reg;
        q_pop           = 1'b0;
        key_we          = 1'b0;
        key_waddr       = free_slot_reg;
        mask_we         = 1'b0;
        mask_waddr      = slot_reg;
        mask_wdata      = mask_reg;
        dep_we          = 1'b0;
        dep_waddr       = DEP_AW'(32'(slot_reg) * DEPS_PER_KEY);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    item_next      = q_item;
                    scan_cnt_next  = '0;
                    free_found_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end

            // Read one key slot a cycle and compare the registered word.
            ST_SCAN:
            begin
                if (scan_cnt_reg != SLOT_CW'(KEY_SLOTS))
                begin
                    rs_vld_next   = 1'b1;
                    rs_idx_next   = scan_cnt_reg[SLOT_W-1:0];
                    scan_cnt_next = scan_cnt_reg + SLOT_CW'(1);
                end
                if (rs_vld_reg && !key_used_reg[rs_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_slot_next  = rs_idx_reg;
                end
                if (hit)
                begin
                    slot_next   = rs_idx_reg;
                    rs_vld_next = 1'b0;
                    state_next  = ST_MASK;
                end
                else if (rs_vld_reg && rs_idx_reg == SLOT_W'(KEY_SLOTS - 1))
                begin
                    rs_vld_next = 1'b0;
                    priority case (item_reg.mode)
                        MODE_RECORD:
                        begin
                            state_next = ST_ALLOC;
                        end
                        MODE_ANALYZE:
                        begin
                            res_need_next = item_reg.last;
                            res_ovf_next  = 1'b0;
                            state_next    = ST_FIN;
                        end
                        default:
                        begin
                            res_need_next = 1'b0;
                            state_next    = ST_FIN;
                        end
                    endcase
                end
            end

            // New key: take the free slot found during the scan, or flag an overflow if there is none.
            ST_ALLOC:
            begin
                res_need_next = 1'b1;
                if (free_found_reg)
                begin
                    key_we       = 1'b1;
                    key_waddr    = free_slot_reg;
                    key_used_next[free_slot_reg] = 1'b1;
                    mask_we      = 1'b1;
                    mask_waddr   = free_slot_reg;
                    mask_wdata   = DEPS_PER_KEY'(1);
                    dep_we       = 1'b1;
                    dep_waddr    = DEP_AW'(32'(free_slot_reg) * DEPS_PER_KEY);
                    res_ovf_next = 1'b0;
                end
                else
                begin
                    res_ovf_next = 1'b1;
                end
                state_next = ST_FIN;
            end

            // The key's entry mask is available.
            ST_MASK:
            begin
                if (item_reg.mode == MODE_RECORD)
                begin
                    res_need_next = 1'b1;
                    if (zero_found)
                    begin
                        mask_we      = 1'b1;
                        mask_wdata   = mask_q | (DEPS_PER_KEY'(1) << zero_idx);
                        dep_we       = 1'b1;
                        dep_waddr    = DEP_AW'(32'(slot_reg) * DEPS_PER_KEY
                                               + 32'(zero_idx));
                        res_ovf_next = 1'b0;
                    end
                    else
                    begin
                        res_ovf_next = 1'b1;
                    end
                    state_next = ST_FIN;
                end
                else
                begin
                    mask_next    = mask_q;
                    iss_cnt_next = '0;
                    state_next   = ST_WALK;
                end
            end

            // Read one list entry a cycle and fold it in.
            ST_WALK:
            begin
                if (iss_cnt_reg != ENT_CW'(DEPS_PER_KEY))
                begin
                    rdv_next     = 1'b1;
                    rd_e_next    = iss_cnt_reg[ENT_W-1:0];
                    iss_cnt_next = iss_cnt_reg + ENT_CW'(1);
                end
                if (rdv_reg && mask_reg[rd_e_reg])
                begin
                    if (item_reg.mode == MODE_ANALYZE)
                    begin
                        if ((item_reg.wr || ent_wr) && ent_txn < item_reg.id &&
                            (!best_found_reg || ent_txn > best_txn_reg))
                        begin
                            best_found_next = 1'b1;
                            best_txn_next   = ent_txn;
                        end
                    end
                    else if (ent_wr == item_reg.wr)
                    begin
                        mask_next[rd_e_reg] = 1'b0;
                    end
                end
                if (iss_cnt_reg == ENT_CW'(DEPS_PER_KEY) && !rdv_reg)
                begin
                    if (item_reg.mode == MODE_ANALYZE)
                    begin
                        res_need_next = item_reg.last;
                        res_ovf_next  = 1'b0;
                    end
                    else
                    begin
                        res_need_next = 1'b0;
                        mask_we       = 1'b1;
                        mask_wdata    = mask_reg;
                        if (mask_reg == '0)
                        begin
                            key_used_next[slot_reg] = 1'b0;
                        end
                    end
                    state_next = ST_FIN;
                end
            end

            // Hand over the result, if the access has one.
            ST_FIN, ST_WAIT:
            begin
                if (!res_need_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_ovf_next   = res_ovf_reg;
                    if (item_reg.mode == MODE_ANALYZE)
                    begin
                        out_found_next  = best_found_reg;
                        out_id_next     = best_found_reg ? 32'(64'(best_txn_reg)) : 32'd0;
                        best_found_next = 1'b0;
                        best_txn_next   = '0;
                    end
                    else
                    begin
                        out_found_next = 1'b0;
                        out_id_next    = 32'd0;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            item_reg       <= '0;
            scan_cnt_reg   <= '0;
            rs_vld_reg     <= 1'b0;
            rs_idx_reg     <= '0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            slot_reg       <= '0;
            mask_reg       <= '0;
            iss_cnt_reg    <= '0;
            rdv_reg        <= 1'b0;
            rd_e_reg       <= '0;
            best_found_reg <= 1'b0;
            best_txn_reg   <= '0;
            res_need_reg   <= 1'b0;
            res_ovf_reg    <= 1'b0;
            key_used_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_id_reg     <= '0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            item_reg       <= item_next;
            scan_cnt_reg   <= scan_cnt_next;
            rs_vld_reg     <= rs_vld_next;
            rs_idx_reg     <= rs_idx_next;
            free_found_reg <= free_found_next;
            free_slot_reg  <= free_slot_next;
            slot_reg       <= slot_next;
            mask_reg       <= mask_next;
            iss_cnt_reg    <= iss_cnt_next;
            rdv_reg        <= rdv_next;
            rd_e_reg       <= rd_e_next;
            best_found_reg <= best_found_next;
            best_txn_reg   <= best_txn_next;
            res_need_reg   <= res_need_next;
            res_ovf_reg    <= res_ovf_next;
            key_used_reg   <= key_used_next;
            out_valid_reg  <= out_valid_next;
            out_found_reg  <= out_found_next;
            out_id_reg     <= out_id_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    // Key store.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= item_reg.key;
        end
        key_q <= key_mem[key_raddr];
    end

    // Entry mask store.
    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[mask_waddr] <= mask_wdata;
        end
        mask_q <= mask_mem[mask_raddr];
    end

    // Entry store: write flag and id.
    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            dep_mem[dep_waddr] <= {item_reg.wr, item_reg.id};
        end
        dep_q <= dep_mem[dep_raddr];
    end

    assign out_valid  = out_valid_reg;
    assign wait_found = out_found_reg;
    assign wait_id    = out_id_reg;
    assign overflow   = out_ovf_reg;

endmodule
